// ===== rtl/sba_pkg.sv =====
// Shared constants for the segregated bin allocator: parameter defaults,
// operation and status codes.
// No dependencies.
package sba_pkg;

	localparam int BLOCK_BYTES_DEF   = 16;
	localparam int BIN_COUNT_DEF     = 32;
	localparam int HEADER_BYTES_DEF  = 8;
	localparam int HEAP_GRANULES_DEF = 4096;

	localparam int ADDR_W = 16;
	localparam int STAT_W = 2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [STAT_W-1:0] STAT_OK        = 2'd0;
	localparam logic [STAT_W-1:0] STAT_OVERSIZE  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EXHAUSTED = 2'd2;

endpackage

// ===== rtl/sba_ram.sv =====
// Generic single-port synchronous RAM with a registered read port.
// No dependencies.
module sba_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             en,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end else begin
				rdata <= mem[addr];
			end
		end
	end

endmodule

// ===== rtl/sba_recip_div.sv =====
// Two-stage divider by a constant: multiply by a truncated reciprocal, then
// one compare-and-subtract correction. No dependencies.
module sba_recip_div #(
	parameter int DIVISOR = 16,
	parameter int XW = 17,
	localparam int QW = XW - $clog2(DIVISOR) + 1,
	localparam int RW = $clog2(DIVISOR)
) (
	input  logic          clk,
	input  logic [XW-1:0] x,
	output logic [QW-1:0] q,
	output logic [RW-1:0] r
);

	// With the reciprocal truncated to XW fractional bits the estimate is
	// either exact or one short.
	localparam int M0 = (2 ** XW) / DIVISOR;
	localparam int MW = $clog2(M0 + 1);
	localparam logic [MW-1:0] RECIP = MW'(M0);
	localparam logic [XW-1:0] DIV_X = XW'(DIVISOR);

	logic [XW+MW-1:0] prod_s1;
	logic [XW-1:0]    x_s1;
	logic [QW-1:0]    q_est;
	logic [XW-1:0]    r_raw;

	always_ff @(posedge clk) begin
		prod_s1 <= (XW+MW)'(x) * (XW+MW)'(RECIP);
		x_s1    <= x;
	end

	always_comb begin
		q_est = QW'(prod_s1 >> XW);
		r_raw = x_s1 - (XW'(q_est) * DIV_X);
	end

	always_ff @(posedge clk) begin
		if (r_raw >= DIV_X) begin
			q <= q_est + QW'(1);
			r <= RW'(r_raw - DIV_X);
		end else begin
			q <= q_est;
			r <= RW'(r_raw);
		end
	end

endmodule

// ===== rtl/segregated_bin_allocator_core.sv =====
// Channel    | Signals                                     | Handshake
// command    | op, request_bytes, payload_addr             | taken when start & !busy
// result     | result_addr, status                         | done strobe, one cycle
//
// Each command passes the two-stage reciprocal divider (DIV1, DIV2), then LOOK.
// Oversize requests, carves from the bump pointer, heap-exhausted failures and
// frees rejected in LOOK raise done from LOOK; a pop from a bin list reads the
// bin-head RAM (POP) then the block RAM (POP2); a push reads the block RAM (FBIN),
// where a bad bin tag rejects the free, then writes both (FPUSH). Busy falls as
// done rises, so no new command is taken before the last one is through.
// Reset empties every bin list through per-bin valid flops and zeroes the
// bump pointer; the block RAM needs no clearing. Results cannot be stalled.
// Depends on sba_pkg, sba_ram and sba_recip_div.
module segregated_bin_allocator_core #(
	parameter int BLOCK_BYTES   = sba_pkg::BLOCK_BYTES_DEF,
	parameter int BIN_COUNT     = sba_pkg::BIN_COUNT_DEF,
	parameter int HEADER_BYTES  = sba_pkg::HEADER_BYTES_DEF,
	parameter int HEAP_GRANULES = sba_pkg::HEAP_GRANULES_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         op,
	input  logic [sba_pkg::ADDR_W-1:0]   request_bytes,
	input  logic [sba_pkg::ADDR_W-1:0]   payload_addr,
	output logic                         done,
	output logic [sba_pkg::ADDR_W-1:0]   result_addr,
	output logic [sba_pkg::STAT_W-1:0]   status
);

	import sba_pkg::*;

	localparam int XW       = ADDR_W + 1;
	localparam int QW       = XW - $clog2(BLOCK_BYTES) + 1;
	localparam int RW       = $clog2(BLOCK_BYTES);
	localparam int BW       = $clog2(BIN_COUNT);
	localparam int GIW      = $clog2(HEAP_GRANULES);
	localparam int FIT      = (65535 - HEADER_BYTES) / BLOCK_BYTES + 1;
	localparam int HEAP_END = (HEAP_GRANULES < FIT) ? HEAP_GRANULES : FIT;
	localparam int PW       = $clog2(HEAP_END + 1);
	localparam int BSW      = BW + 1 + GIW;
	localparam int MAX_ADJ  = (BIN_COUNT - 1) * BLOCK_BYTES;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_DIV1  = 3'd1;
	localparam logic [2:0] ST_DIV2  = 3'd2;
	localparam logic [2:0] ST_LOOK  = 3'd3;
	localparam logic [2:0] ST_POP   = 3'd4;
	localparam logic [2:0] ST_POP2  = 3'd5;
	localparam logic [2:0] ST_FBIN  = 3'd6;
	localparam logic [2:0] ST_FPUSH = 3'd7;

	logic [2:0]           state_q, state_d;
	logic                 op_q;
	logic                 bad_q;
	logic [XW-1:0]        x_q;
	logic [BW-1:0]        bin_q, bin_d;
	logic [GIW-1:0]       g_q, g_d;
	logic [PW-1:0]        bump_q;
	logic [BIN_COUNT-1:0] head_vld_q;

	logic [QW-1:0]        div_q;
	logic [RW-1:0]        div_r;

	logic                 hr_en, hr_we;
	logic [BW-1:0]        hr_addr;
	logic [GIW-1:0]       hr_wdata, hr_rdata;
	logic                 bs_en, bs_we;
	logic [GIW-1:0]       bs_addr;
	logic [BSW-1:0]       bs_wdata, bs_rdata;

	logic [BW-1:0]        bs_bin;
	logic                 bs_nvld;
	logic [GIW-1:0]       bs_next;

	logic                 resp;
	logic [ADDR_W-1:0]    resp_addr;
	logic [STAT_W-1:0]    resp_stat;
	logic                 bump_inc;
	logic                 vld_we;
	logic                 vld_val;

	logic [BW-1:0]        alloc_bin;
	logic [GIW-1:0]       bump_g;
	logic [GIW-1:0]       free_g;
	logic                 carve_fail;
	logic                 free_reject;

	sba_recip_div #(
		.DIVISOR (BLOCK_BYTES),
		.XW      (XW)
	) u_div (
		.clk (clk),
		.x   (x_q),
		.q   (div_q),
		.r   (div_r)
	);

	sba_ram #(
		.WIDTH (GIW),
		.DEPTH (BIN_COUNT)
	) u_heads (
		.clk   (clk),
		.en    (hr_en),
		.we    (hr_we),
		.addr  (hr_addr),
		.wdata (hr_wdata),
		.rdata (hr_rdata)
	);

	sba_ram #(
		.WIDTH (BSW),
		.DEPTH (HEAP_GRANULES)
	) u_blocks (
		.clk   (clk),
		.en    (bs_en),
		.we    (bs_we),
		.addr  (bs_addr),
		.wdata (bs_wdata),
		.rdata (bs_rdata)
	);

	assign busy = (state_q != ST_IDLE);
	assign {bs_bin, bs_nvld, bs_next} = bs_rdata;

	always_comb begin
		alloc_bin   = BW'(div_q);
		bump_g      = GIW'(bump_q);
		free_g      = GIW'(div_q);
		carve_fail  = (XW'(alloc_bin) + XW'(bump_q)) > XW'(HEAP_END);
		// A free is dropped if below the header size, misaligned or not below the bump pointer.
		free_reject = bad_q || (div_r != '0) || (XW'(div_q) >= XW'(bump_q));
	end

	always_comb begin
		state_d   = state_q;
		bin_d     = bin_q;
		g_d       = g_q;
		hr_en     = 1'b0;
		hr_we     = 1'b0;
		hr_addr   = bin_q;
		hr_wdata  = g_q;
		bs_en     = 1'b0;
		bs_we     = 1'b0;
		bs_addr   = g_q;
		bs_wdata  = {bin_q, head_vld_q[bin_q], hr_rdata};
		resp      = 1'b0;
		resp_addr = '0;
		resp_stat = STAT_OK;
		bump_inc  = 1'b0;
		vld_we    = 1'b0;
		vld_val   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = ST_DIV1;
				end
			end
			ST_DIV1: begin
				state_d = ST_DIV2;
			end
			ST_DIV2: begin
				state_d = ST_LOOK;
			end
			ST_LOOK: begin
				if (op_q == OP_ALLOC) begin
					priority if (bad_q) begin
						resp      = 1'b1;
						resp_stat = STAT_OVERSIZE;
						state_d   = ST_IDLE;
					end else if (head_vld_q[alloc_bin]) begin
						bin_d   = alloc_bin;
						hr_en   = 1'b1;
						hr_addr = alloc_bin;
						state_d = ST_POP;
					end else if (carve_fail) begin
						resp      = 1'b1;
						resp_stat = STAT_EXHAUSTED;
						state_d   = ST_IDLE;
					end else begin
						// Carve a fresh block and tag it with its bin.
						bs_en     = 1'b1;
						bs_we     = 1'b1;
						bs_addr   = bump_g;
						bs_wdata  = {alloc_bin, 1'b0, {GIW{1'b0}}};
						bump_inc  = 1'b1;
						resp      = 1'b1;
						resp_addr = ADDR_W'(32'(bump_g) * BLOCK_BYTES + HEADER_BYTES);
						state_d   = ST_IDLE;
					end
				end else begin
					if (free_reject) begin
						resp    = 1'b1;
						state_d = ST_IDLE;
					end else begin
						g_d     = free_g;
						bs_en   = 1'b1;
						bs_addr = free_g;
						state_d = ST_FBIN;
					end
				end
			end
			ST_POP: begin
				g_d     = hr_rdata;
				bs_en   = 1'b1;
				bs_addr = hr_rdata;
				state_d = ST_POP2;
			end
			ST_POP2: begin
				vld_we    = 1'b1;
				vld_val   = bs_nvld;
				hr_en     = 1'b1;
				hr_we     = 1'b1;
				hr_wdata  = bs_next;
				resp      = 1'b1;
				resp_addr = ADDR_W'(32'(g_q) * BLOCK_BYTES + HEADER_BYTES);
				state_d   = ST_IDLE;
			end
			ST_FBIN: begin
				if (int'(bs_bin) >= BIN_COUNT) begin
					resp    = 1'b1;
					state_d = ST_IDLE;
				end else begin
					bin_d   = bs_bin;
					hr_en   = 1'b1;
					hr_addr = bs_bin;
					state_d = ST_FPUSH;
				end
			end
			ST_FPUSH: begin
				// The block links to the old head and becomes the new head.
				bs_en   = 1'b1;
				bs_we   = 1'b1;
				hr_en   = 1'b1;
				hr_we   = 1'b1;
				vld_we  = 1'b1;
				vld_val = 1'b1;
				resp    = 1'b1;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			bump_q     <= '0;
			head_vld_q <= '0;
			done       <= 1'b0;
		end else begin
			state_q <= state_d;
			done    <= resp;
			if (bump_inc) begin
				bump_q <= bump_q + PW'(alloc_bin);
			end
			if (vld_we) begin
				head_vld_q[bin_q] <= vld_val;
			end
		end
	end

	always_ff @(posedge clk) begin
		bin_q <= bin_d;
		g_q   <= g_d;
		if (resp) begin
			result_addr <= resp_addr;
			status      <= resp_stat;
		end
		if (start && !busy) begin
			op_q <= op;
			if (op == OP_ALLOC) begin
				// Dividing header-adjusted size plus one block less one rounds up.
				x_q   <= XW'(request_bytes) + XW'(HEADER_BYTES + BLOCK_BYTES - 1);
				bad_q <= (XW'(request_bytes) + XW'(HEADER_BYTES)) > XW'(MAX_ADJ);
			end else begin
				x_q   <= XW'(payload_addr) - XW'(HEADER_BYTES);
				bad_q <= payload_addr < ADDR_W'(HEADER_BYTES);
			end
		end
	end

endmodule
